// ===== hdl/nls_pkg.sv =====
// ----------------------------------------------------------------------------
// nls_pkg: shared types and constants of the nibble link symbol sender
// Line codes, step positions of a character frame, the command word passed
// from the front end to the back end, and the code lookup per step.
// ----------------------------------------------------------------------------
`default_nettype none

package nls_pkg;

    localparam int SYM_W     = 3;
    localparam int CODE_W    = 4;
    localparam int PORT_W    = 8;
    localparam int STEP_N    = 8;
    localparam int STEP_W    = 3;
    localparam int CMD_DEPTH = 2;

    localparam logic [CODE_W-1:0] CODE_START = 4'h8;
    localparam logic [CODE_W-1:0] CODE_SAME  = 4'hA;
    localparam logic [CODE_W-1:0] CODE_STOP  = 4'hF;

    // Step positions inside one character frame, in send order.
    localparam logic [STEP_W-1:0] STEP_LEAD_SAME = 3'd0;
    localparam logic [STEP_W-1:0] STEP_START     = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SYM0      = 3'd2;
    localparam logic [STEP_W-1:0] STEP_SAME01    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_SYM1      = 3'd4;
    localparam logic [STEP_W-1:0] STEP_SAME12    = 3'd5;
    localparam logic [STEP_W-1:0] STEP_SYM2      = 3'd6;
    localparam logic [STEP_W-1:0] STEP_STOP      = 3'd7;

    // One classified character: a bit per step that is sent, and the symbols.
    typedef struct packed {
        logic [STEP_N-1:0] mask;
        logic [SYM_W-1:0]  sym0;
        logic [SYM_W-1:0]  sym1;
        logic [SYM_W-1:0]  sym2;
    } t_cmd;

    function automatic logic [CODE_W-1:0] step_code(input logic [STEP_W-1:0] step,
                                                    input t_cmd cmd);
        logic [CODE_W-1:0] code;
        unique case (step)
            STEP_LEAD_SAME: code = CODE_SAME;
            STEP_START:     code = CODE_START;
            STEP_SYM0:      code = {1'b0, cmd.sym0};
            STEP_SAME01:    code = CODE_SAME;
            STEP_SYM1:      code = {1'b0, cmd.sym1};
            STEP_SAME12:    code = CODE_SAME;
            STEP_SYM2:      code = {1'b0, cmd.sym2};
            STEP_STOP:      code = CODE_STOP;
            default:        code = CODE_STOP;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/nls_front.sv =====
// ----------------------------------------------------------------------------
// nls_front: character classifier
// Splits each accepted byte into symbols, decides which SAME and STOP codes
// the frame needs and keeps the tail symbol history between characters.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire logic                        i_full,
    input  wire logic [7:0]                  i_char_byte,
    input  wire logic                        i_final_char,
    output logic                             o_wr,
    output nls_pkg::t_cmd                    o_cmd
);
    import nls_pkg::*;

    logic [SYM_W-1:0] r_prev_tail, n_prev_tail;
    logic             r_prev_valid, n_prev_valid;
    logic [SYM_W-1:0] s0, s1, s2;
    logic             accept;

    assign accept = i_push && !i_full;
    assign s0 = i_char_byte[2:0];
    assign s1 = i_char_byte[5:3];
    assign s2 = {1'b0, i_char_byte[7:6]};

    always_comb begin
        o_cmd.sym0 = s0;
        o_cmd.sym1 = s1;
        o_cmd.sym2 = s2;
        o_cmd.mask = '0;
        o_cmd.mask[STEP_LEAD_SAME] = r_prev_valid && (r_prev_tail == s0);
        o_cmd.mask[STEP_START]     = 1'b1;
        o_cmd.mask[STEP_SYM0]      = 1'b1;
        o_cmd.mask[STEP_SAME01]    = (s0 == s1);
        o_cmd.mask[STEP_SYM1]      = 1'b1;
        o_cmd.mask[STEP_SAME12]    = (s1 == s2);
        o_cmd.mask[STEP_SYM2]      = 1'b1;
        o_cmd.mask[STEP_STOP]      = i_final_char;
    end

    assign o_wr = accept;

    // A final character ends the transmission and clears the history.
    always_comb begin
        n_prev_tail  = r_prev_tail;
        n_prev_valid = r_prev_valid;
        if (accept) begin
            n_prev_valid = !i_final_char;
            n_prev_tail  = i_final_char ? '0 : s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_tail  <= '0;
            r_prev_valid <= 1'b0;
        end else begin
            r_prev_tail  <= n_prev_tail;
            r_prev_valid <= n_prev_valid;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nls_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// nls_cmd_fifo: command queue between front end and back end
// A short register queue of classified characters, first in first out.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_cmd_fifo #(
    parameter int Depth = nls_pkg::CMD_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire nls_pkg::t_cmd i_cmd,
    input  wire logic          i_rd,
    output nls_pkg::t_cmd      o_cmd,
    output logic               o_full,
    output logic               o_empty
);
    import nls_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

    t_cmd            r_slot [Depth];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (!o_full || i_rd))
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty)
        else $error("command queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("command queue count out of range");

endmodule

`default_nettype wire

// ===== hdl/nls_back.sv =====
// ----------------------------------------------------------------------------
// nls_back: line code sequencer
// Walks the steps of one classified character, one code per cycle unless a
// held word is not popped, and keeps each port word in a register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_upper_half_lane,
    input  wire nls_pkg::t_cmd         i_cmd,
    input  wire logic                  i_cmd_empty,
    output logic                       o_cmd_rd,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output logic [7:0]                 o_port_value,
    output logic                       o_run_end
);
    import nls_pkg::*;

    t_cmd              r_cmd;
    logic [STEP_N-1:0] r_mask, n_mask;
    logic [STEP_N-1:0] low_bit, rest_mask, load_mask;
    logic [STEP_W-1:0] step;
    logic [CODE_W-1:0] code;
    logic              advance, load;
    logic              r_out_valid, n_out_valid;
    logic [PORT_W-1:0] r_port, n_port;
    logic              r_run_end, n_run_end;

    // Lowest pending step is sent next.
    assign low_bit   = r_mask & (~r_mask + 1'b1);
    assign rest_mask = r_mask & ~low_bit;

    always_comb begin
        step = '0;
        for (int i = STEP_N - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                step = STEP_W'(i);
            end
        end
    end

    assign code    = step_code(step, r_cmd);
    assign advance = (r_mask != '0) && (!r_out_valid || i_pop);

    // Take the next character as soon as the current one has no steps left.
    assign load_mask = advance ? rest_mask : r_mask;
    assign load      = (load_mask == '0) && !i_cmd_empty;
    assign o_cmd_rd  = load;

    always_comb begin
        n_mask      = load ? i_cmd.mask : load_mask;
        n_out_valid = r_out_valid;
        n_port      = r_port;
        n_run_end   = r_run_end;
        if (advance) begin
            n_out_valid = 1'b1;
            n_port      = i_upper_half_lane ? {code, 4'h0} : {4'h0, code};
            n_run_end   = (rest_mask == '0);
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_port    <= n_port;
        r_run_end <= n_run_end;
        if (load) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_port_value = r_port;
    assign o_run_end    = r_run_end;

    a_frame_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (i_cmd.mask[STEP_START] && i_cmd.mask[STEP_SYM0]
                  && i_cmd.mask[STEP_SYM1] && i_cmd.mask[STEP_SYM2]))
        else $error("character frame without start or symbols");

    a_load_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> $past(r_mask == '0 || (advance && rest_mask == '0)))
        else $error("new character loaded over pending steps");

endmodule

`default_nettype wire

// ===== hdl/nibble_link_symbol_sender.sv =====
// ----------------------------------------------------------------------------
// nibble_link_symbol_sender: character to nibble line code sender
// Turns character bytes into 4-bit line codes placed in one half of a port.
// ----------------------------------------------------------------------------
// Usage:
// The input side is a queue: a character beat (i_char_byte, i_final_char) is
// taken at a clock edge with push high and full low. Each byte is sent as
// START, its three 3-bit symbols (least significant first), with SAME placed
// between equal neighbors, also before START when the previous character's
// last symbol equals this character's first one. After a character marked
// final, STOP follows and the symbol history is cleared.
// The result side is a queue as well: while empty is low the oldest port
// word sits on o_port_value and o_run_end, and pop takes it. o_run_end marks
// the last word of a character. i_cfg_wen/i_cfg_wdata set the lane: 0 puts
// the code into bits 3:0, 1 into bits 7:4; write it only while idle.
// An accepted beat passes the command queue and the step mask register
// before its first word reaches the output register. The back end sends
// one word per cycle while words are popped; a character is four to eight
// words. A short command queue decouples the classifier from the sequencer,
// so beats keep being accepted while words are still going out. When the
// receiver stalls, the output register holds, the queue fills and full rises.
// Reset empties the queue and the output and clears the history and lane.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_link_symbol_sender #(
    parameter int CmdDepth = nls_pkg::CMD_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wen,
    input  wire logic        i_cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_char_byte,
    input  wire logic        i_final_char,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_port_value,
    output logic             o_run_end
);
    import nls_pkg::*;

    logic r_upper_half_lane;
    logic fifo_wr, fifo_rd, fifo_empty;
    t_cmd front_cmd, queue_cmd;

    // Lane select register; the back end reads it when it forms a port word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_half_lane <= 1'b0;
        end else if (i_cfg_wen) begin
            r_upper_half_lane <= i_cfg_wdata;
        end
    end

    nls_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_char_byte  (i_char_byte),
        .i_final_char (i_final_char),
        .o_wr         (fifo_wr),
        .o_cmd        (front_cmd)
    );

    nls_cmd_fifo #(
        .Depth (CmdDepth)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fifo_wr),
        .i_cmd   (front_cmd),
        .i_rd    (fifo_rd),
        .o_cmd   (queue_cmd),
        .o_full  (full),
        .o_empty (fifo_empty)
    );

    nls_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_upper_half_lane (r_upper_half_lane),
        .i_cmd             (queue_cmd),
        .i_cmd_empty       (fifo_empty),
        .o_cmd_rd          (fifo_rd),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_port_value      (o_port_value),
        .o_run_end         (o_run_end)
    );

endmodule

`default_nettype wire
